@@ hw/rtl/msed_pkg.sv @@
// Package: shared types and constants of the multi-sequence event detector.
`timescale 1ns / 1ps

package msed_pkg;

	// defaults for the top-level parameters
	localparam int NUM_SEQ_DEF    = 4;
	localparam int MAX_LEN_DEF    = 8;
	localparam int EVENT_BITS_DEF = 6;

	// register file geometry
	localparam int SEQ_REGS   = 4;
	localparam int SEQ_W      = 60;
	localparam int ELEM_W     = 7;
	localparam int LAST_LSB   = 56;
	localparam int LAST_W     = 4;
	localparam int COUNT_W    = 3;
	localparam int PDATA_W    = 64;
	localparam int PADDR_W    = 6;
	localparam int REG_IDX_W  = 3;
	localparam int REG_LSB    = 3;

	// payload widths
	localparam int EVENT_W  = 6;
	localparam int STATUS_W = 2;
	localparam int MASK_W   = 4;
	localparam int FIRST_W  = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORE = 2'd0,
		ST_WAIT   = 2'd1,
		ST_ENDED  = 2'd2,
		ST_NONE   = 2'd3
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LEGAL = 3'd0,
		REG_COUNT = 3'd1,
		REG_SEQ0  = 3'd2,
		REG_SEQ1  = 3'd3,
		REG_SEQ2  = 3'd4,
		REG_SEQ3  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [PDATA_W-1:0]              legal_mask;
		logic [COUNT_W-1:0]              seq_count;
		logic [SEQ_REGS-1:0][SEQ_W-1:0]  seq;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic pending;
	} lane_res_t;

endpackage

@@ hw/rtl/msed_event_if.sv @@
// Interface: event request channel (valid, ready, event ID).
`timescale 1ns / 1ps

interface msed_event_if;
	logic                          valid;
	logic                          ready;
	logic [msed_pkg::EVENT_W-1:0]  event_id;

	modport source (output valid, output event_id, input ready);
	modport sink   (input valid, input event_id, output ready);
endinterface

@@ hw/rtl/msed_result_if.sv @@
// Interface: result request channel (valid, ready, status, done mask, first done).
`timescale 1ns / 1ps

interface msed_result_if;
	logic                           valid;
	logic                           ready;
	logic [msed_pkg::STATUS_W-1:0]  status;
	logic [msed_pkg::MASK_W-1:0]    done_mask;
	logic [msed_pkg::FIRST_W-1:0]   first_done;

	modport source (output valid, output status, output done_mask, output first_done,
		input ready);
	modport sink   (input valid, input status, input done_mask, input first_done,
		output ready);
endinterface

@@ hw/rtl/msed_regs.sv @@
// Module: APB-style configuration register file of the event detector.
`timescale 1ns / 1ps

module msed_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [msed_pkg::PADDR_W-1:0]   paddr,
	input  logic [msed_pkg::PDATA_W-1:0]   pwdata,
	output logic [msed_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output msed_pkg::cfg_t                 cfg
);

	msed_pkg::cfg_t                    cfg_q;
	logic [msed_pkg::REG_IDX_W-1:0]    idx;
	logic                              wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[msed_pkg::REG_LSB +: msed_pkg::REG_IDX_W];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				msed_pkg::REG_LEGAL: cfg_q.legal_mask <= pwdata;
				msed_pkg::REG_COUNT: cfg_q.seq_count  <= pwdata[msed_pkg::COUNT_W-1:0];
				msed_pkg::REG_SEQ0:  cfg_q.seq[0]     <= pwdata[msed_pkg::SEQ_W-1:0];
				msed_pkg::REG_SEQ1:  cfg_q.seq[1]     <= pwdata[msed_pkg::SEQ_W-1:0];
				msed_pkg::REG_SEQ2:  cfg_q.seq[2]     <= pwdata[msed_pkg::SEQ_W-1:0];
				msed_pkg::REG_SEQ3:  cfg_q.seq[3]     <= pwdata[msed_pkg::SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			msed_pkg::REG_LEGAL: prdata = cfg_q.legal_mask;
			msed_pkg::REG_COUNT: prdata = msed_pkg::PDATA_W'(cfg_q.seq_count);
			msed_pkg::REG_SEQ0:  prdata = msed_pkg::PDATA_W'(cfg_q.seq[0]);
			msed_pkg::REG_SEQ1:  prdata = msed_pkg::PDATA_W'(cfg_q.seq[1]);
			msed_pkg::REG_SEQ2:  prdata = msed_pkg::PDATA_W'(cfg_q.seq[2]);
			msed_pkg::REG_SEQ3:  prdata = msed_pkg::PDATA_W'(cfg_q.seq[3]);
			default:             prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/msed_lane.sv @@
// Module: progress tracker for one event sequence.
`timescale 1ns / 1ps

module msed_lane #(
	parameter int MAX_LEN    = msed_pkg::MAX_LEN_DEF,
	parameter int EVENT_BITS = msed_pkg::EVENT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic                          legal,
	input  logic [EVENT_BITS-1:0]         ev,
	input  logic [msed_pkg::SEQ_W-1:0]    seq,
	output msed_pkg::lane_res_t           res
);

	localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [msed_pkg::LAST_W-1:0] LAST_MAX = msed_pkg::LAST_W'(MAX_LEN - 1);

	logic [PW-1:0]                          progress_q;
	logic [PW-1:0]                          progress_d;
	logic [PW-1:0]                          last;
	logic [PW-1:0]                          p;
	logic [msed_pkg::LAST_W-1:0]            last_raw;
	logic [MAX_LEN-1:0][msed_pkg::ELEM_W-1:0] elems;
	logic [msed_pkg::ELEM_W-1:0]            elem;
	logic                                   hit;

	for (genvar k = 0; k < MAX_LEN; k++) begin : g_elem
		assign elems[k] = seq[msed_pkg::ELEM_W*k +: msed_pkg::ELEM_W];
	end

	assign last_raw = seq[msed_pkg::LAST_LSB +: msed_pkg::LAST_W];
	assign last     = (last_raw > LAST_MAX) ? PW'(LAST_MAX) : PW'(last_raw);
	// progress left over from an older length restarts at element zero
	assign p        = (progress_q > last) ? '0 : progress_q;
	assign elem     = elems[p];
	assign hit      = elem[msed_pkg::ELEM_W-1] || (elem[EVENT_BITS-1:0] == ev);

	always_comb begin
		progress_d  = '0;
		res.done    = 1'b0;
		res.pending = 1'b0;
		if (legal && hit) begin
			if (p == last) begin
				res.done = 1'b1;
			end else begin
				progress_d  = p + PW'(1);
				res.pending = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			progress_q <= '0;
		end else if (upd) begin
			progress_q <= progress_d;
		end
	end

endmodule

@@ hw/rtl/multi_sequence_event_detector.sv @@
// Module: top level of the multi-sequence event detector.
`timescale 1ns / 1ps
// Pipeline: an accepted event request goes to the input register, then its result to
//   the result register, with the sequence match in between.
// Throughput: one event per cycle unless results stall; progress loops in one register.
// Reset (arst_n low, asynchronous): progress counters, configuration and both
//   pipeline valids clear; there is no clearing pass.

module multi_sequence_event_detector #(
	parameter int NUM_SEQ    = msed_pkg::NUM_SEQ_DEF,
	parameter int MAX_LEN    = msed_pkg::MAX_LEN_DEF,
	parameter int EVENT_BITS = msed_pkg::EVENT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msed_pkg::PADDR_W-1:0]  paddr,
	input  logic [msed_pkg::PDATA_W-1:0]  pwdata,
	output logic [msed_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	msed_event_if.sink                    events,
	msed_result_if.source                 results
);

	// only as many lanes as both the build and the register file allow
	localparam int LANES = (NUM_SEQ < msed_pkg::SEQ_REGS) ? NUM_SEQ : msed_pkg::SEQ_REGS;
	localparam logic [msed_pkg::COUNT_W-1:0] LANES_C = msed_pkg::COUNT_W'(LANES);

	msed_pkg::cfg_t                   cfg;

	// stage 1: registered event
	logic                             valid_s1;
	logic [EVENT_BITS-1:0]            ev_s1;

	// stage 2: result register
	logic                             valid_s2;
	msed_pkg::status_t                status_s2;
	logic [msed_pkg::MASK_W-1:0]      done_s2;
	logic [msed_pkg::FIRST_W-1:0]     first_s2;

	logic                             fire;
	logic                             accept;
	logic                             legal;
	logic [msed_pkg::COUNT_W-1:0]     count;
	msed_pkg::lane_res_t              lane_res [LANES];
	logic [LANES-1:0]                 lane_on;
	logic [msed_pkg::MASK_W-1:0]      done_c;
	logic                             any_pending;
	msed_pkg::status_t                status_c;
	logic [msed_pkg::FIRST_W-1:0]     first_c;

	msed_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: the result register drains or is empty -> stage 1 moves on,
	// and stage 1 takes a new request whenever it is empty or moving.
	assign fire          = valid_s1 && (!valid_s2 || results.ready);
	assign events.ready  = !valid_s1 || fire;
	assign accept        = events.valid && events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= events.event_id[EVENT_BITS-1:0];
		end
	end

	// count in use, clamped to the lanes built
	assign count = (cfg.seq_count > LANES_C) ? LANES_C : cfg.seq_count;
	assign legal = cfg.legal_mask[ev_s1];

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		// lanes beyond the count in use keep their progress
		assign lane_on[i] = msed_pkg::COUNT_W'(i) < count;

		msed_lane #(
			.MAX_LEN    (MAX_LEN),
			.EVENT_BITS (EVENT_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.upd    (fire && lane_on[i]),
			.legal  (legal),
			.ev     (ev_s1),
			.seq    (cfg.seq[i]),
			.res    (lane_res[i])
		);
	end

	always_comb begin
		done_c      = '0;
		any_pending = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			done_c[i]   = lane_res[i].done && lane_on[i];
			any_pending = any_pending || (lane_res[i].pending && lane_on[i]);
		end
	end

	// lowest completed lane, zero when none
	always_comb begin
		first_c = '0;
		for (int i = msed_pkg::MASK_W - 1; i >= 0; i--) begin
			if (done_c[i]) begin
				first_c = msed_pkg::FIRST_W'(i);
			end
		end
	end

	// precedence: nothing configured, then ended, then waiting, then ignore
	always_comb begin
		if (count == '0) begin
			status_c = msed_pkg::ST_NONE;
		end else if (done_c != '0) begin
			status_c = msed_pkg::ST_ENDED;
		end else if (any_pending) begin
			status_c = msed_pkg::ST_WAIT;
		end else begin
			status_c = msed_pkg::ST_IGNORE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status_c;
			done_s2   <= done_c;
			first_s2  <= first_c;
		end
	end

	assign results.valid      = valid_s2;
	assign results.status     = status_s2;
	assign results.done_mask  = done_s2;
	assign results.first_done = first_s2;

endmodule

@@ hw/rtl/msed_checker.sv @@
// Checker: port-level assertions for the event detector, with its bind.
`timescale 1ns / 1ps

module msed_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [msed_pkg::STATUS_W-1:0]  status,
	input logic [msed_pkg::MASK_W-1:0]    done_mask,
	input logic [msed_pkg::FIRST_W-1:0]   first_done
);

	// a stalled result request holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(done_mask)
			&& $stable(first_done))
		else $error("result changed while stalled");

	// nothing configured reports no completions
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == msed_pkg::ST_NONE |-> done_mask == '0 && first_done == '0)
		else $error("completion reported with no sequences configured");

	// ended status exactly when some sequence completed
	a_ended: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((done_mask != '0) == (status == msed_pkg::ST_ENDED)))
		else $error("status and done mask disagree");

	// first_done names the lowest completed sequence
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_mask != '0 |-> done_mask[first_done]
			&& ((done_mask & ((4'b0001 << first_done) - 4'b0001)) == '0))
		else $error("first_done is not the lowest completed sequence");

endmodule

bind multi_sequence_event_detector msed_checker u_msed_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.status     (results.status),
	.done_mask  (results.done_mask),
	.first_done (results.first_done)
);
